>>> rtl/unique_effect_slot_table_top_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the effect slot table
// Implication checks on the shared clock and reset, empty in synthesis.
// ---------------------------------------------------------------------------
`ifndef UNIQUE_EFFECT_SLOT_TABLE_TOP_MACROS_SVH
`define UNIQUE_EFFECT_SLOT_TABLE_TOP_MACROS_SVH

`ifndef SYNTHESIS
`define UEST_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define UEST_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define UEST_ASSERT_IMP(lbl, ante, cons)
`define UEST_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

>>> rtl/uest_pkg.sv
// ---------------------------------------------------------------------------
// Effect slot table package
// Request and result types and operation codes.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package uest_pkg;

  localparam int KIND_W   = 4;
  localparam int POS_W    = 4;
  localparam int EFFECT_W = 4;
  localparam int SW_W     = 3;

  localparam logic [KIND_W-1:0] KIND_ASSIGN   = 4'd0;
  localparam logic [KIND_W-1:0] KIND_CLEAR    = 4'd1;
  localparam logic [KIND_W-1:0] KIND_SWAP     = 4'd2;
  localparam logic [KIND_W-1:0] KIND_ENABLE   = 4'd3;
  localparam logic [KIND_W-1:0] KIND_ACTIVE   = 4'd4;
  localparam logic [KIND_W-1:0] KIND_SWITCHES = 4'd5;
  localparam logic [KIND_W-1:0] KIND_QENABLED = 4'd6;
  localparam logic [KIND_W-1:0] KIND_QACTIVE  = 4'd7;
  localparam logic [KIND_W-1:0] KIND_DEFAULTS = 4'd8;

  typedef struct packed {
    logic [KIND_W-1:0]   kind;
    logic [POS_W-1:0]    pos_a;
    logic [POS_W-1:0]    pos_b;
    logic [EFFECT_W-1:0] effect;
    logic                enable;
    logic [SW_W-1:0]     switches;
  } cmd_t;

  typedef struct packed {
    logic                ok;
    logic                is_enabled;
    logic [EFFECT_W-1:0] cur_effect;
  } res_t;

  typedef struct packed {
    logic                used;
    logic [EFFECT_W-1:0] effect;
  } slot_t;

endpackage

>>> rtl/unique_effect_slot_table_top.sv
// ---------------------------------------------------------------------------
// Unique effect slot table
// Slot table with a reverse map from effect id to slot, both in memories.
// ---------------------------------------------------------------------------
//
//   Channel  Signals                     Content
//   cmd      cmd_valid, cmd_stall, cmd   one table operation per request
//   res      res_valid, res_stall, res   one result per request
//
// A request passes through accept with memory read, execute, and result
// load. An in-range assign or swap adds a second execute state for the
// second write on the single write port of each memory. Entries carry valid
// bits, so reset and the defaults operation take effect at once. A stalled
// result holds the block only when the next result is ready to be loaded.
`timescale 1ns / 1ps

module unique_effect_slot_table_top
  import uest_pkg::*;
#(
  parameter int SLOTS   = 8,
  parameter int EFFECTS = 3
) (
  input  logic clk,
  input  logic rst,
  input  logic cmd_valid,
  output logic cmd_stall,
  input  cmd_t cmd,
  output logic res_valid,
  input  logic res_stall,
  output res_t res
);

`include "unique_effect_slot_table_top_macros.svh"

  localparam int AW = $clog2(SLOTS);
  localparam int EW = (EFFECTS > 1) ? $clog2(EFFECTS) : 1;
  localparam logic [SLOTS-1:0] ON_RESET = SLOTS'(1);

  typedef struct packed {
    logic          placed;
    logic [AW-1:0] slot;
  } map_t;

  typedef enum logic [1:0] {ST_IDLE, ST_EXEC, ST_EXEC2, ST_DONE} state_t;

  function automatic slot_t slot_default(logic [AW-1:0] i);
    slot_t s;
    s.used   = (int'(i) < 3) && (int'(i) < EFFECTS);
    s.effect = s.used ? EFFECT_W'(i) : '0;
    return s;
  endfunction

  function automatic map_t map_default(logic [EW-1:0] e);
    map_t m;
    m.placed = int'(e) < 3;
    m.slot   = m.placed ? AW'(e) : '0;
    return m;
  endfunction

  state_t             state;
  cmd_t               req;
  res_t               res_q;
  logic [AW-1:0]      cur_slot;
  logic [SLOTS-1:0]   slot_on;
  logic [SLOTS-1:0]   slot_vld;
  logic [EFFECTS-1:0] map_vld;

  slot_t              slot_mem [SLOTS];
  map_t               map_mem [EFFECTS];

  slot_t              rd_a;
  slot_t              rd_b;
  map_t               rd_m;
  logic               rd_a_vld;
  logic               rd_b_vld;
  logic               rd_m_vld;
  logic [AW-1:0]      ra;
  logic [AW-1:0]      rd_addr_a;

  logic               accept;
  slot_t              sa;
  slot_t              sb;
  map_t               mp;
  logic [AW-1:0]      pa;
  logic [AW-1:0]      pb;
  logic [EW-1:0]      ei;
  logic               a_ok;
  logic               b_ok;
  logic               e_ok;
  logic               where_hit;
  logic               two_step;
  res_t               res_next;

  logic               slot_we;
  logic [AW-1:0]      slot_waddr;
  slot_t              slot_wdata;
  logic               map_we;
  logic [EW-1:0]      map_waddr;
  map_t               map_wdata;

  assign cmd_stall = (state != ST_IDLE);
  assign accept    = cmd_valid && !cmd_stall;
  assign rd_addr_a = (cmd.kind == KIND_QACTIVE) ? cur_slot : cmd.pos_a[AW-1:0];

  always_ff @(posedge clk) begin
    if (accept) begin
      rd_a     <= slot_mem[rd_addr_a];
      rd_a_vld <= slot_vld[rd_addr_a];
      rd_b     <= slot_mem[cmd.pos_b[AW-1:0]];
      rd_b_vld <= slot_vld[cmd.pos_b[AW-1:0]];
      rd_m     <= map_mem[cmd.effect[EW-1:0]];
      rd_m_vld <= map_vld[cmd.effect[EW-1:0]];
      ra       <= rd_addr_a;
    end
  end

  always_ff @(posedge clk) begin
    if (slot_we) begin
      slot_mem[slot_waddr] <= slot_wdata;
    end
    if (map_we) begin
      map_mem[map_waddr] <= map_wdata;
    end
  end

  assign pa        = req.pos_a[AW-1:0];
  assign pb        = req.pos_b[AW-1:0];
  assign ei        = req.effect[EW-1:0];
  assign a_ok      = 32'(req.pos_a) < SLOTS;
  assign b_ok      = 32'(req.pos_b) < SLOTS;
  assign e_ok      = 32'(req.effect) < EFFECTS;
  assign sa        = rd_a_vld ? rd_a : slot_default(ra);
  assign sb        = rd_b_vld ? rd_b : slot_default(pb);
  assign mp        = rd_m_vld ? rd_m : map_default(ei);
  assign where_hit = mp.placed && (mp.slot != pa);
  assign two_step  = ((req.kind == KIND_ASSIGN) && a_ok && e_ok) ||
                     ((req.kind == KIND_SWAP) && a_ok && b_ok);

  always_comb begin
    res_next = '0;
    case (req.kind)
      KIND_ASSIGN:   res_next.ok = a_ok && e_ok;
      KIND_CLEAR:    res_next.ok = a_ok;
      KIND_SWAP:     res_next.ok = a_ok && b_ok;
      KIND_ENABLE:   res_next.ok = a_ok;
      KIND_ACTIVE:   res_next.ok = a_ok;
      KIND_SWITCHES: res_next.ok = 1'b1;
      KIND_QENABLED: begin
        res_next.ok         = e_ok;
        res_next.is_enabled = e_ok && mp.placed && slot_on[mp.slot];
      end
      KIND_QACTIVE: begin
        res_next.ok         = sa.used;
        res_next.cur_effect = sa.used ? sa.effect : '0;
      end
      KIND_DEFAULTS: res_next.ok = 1'b1;
      default:       res_next = '0;
    endcase
  end

  always_comb begin
    slot_we    = 1'b0;
    slot_waddr = pa;
    slot_wdata = '0;
    map_we     = 1'b0;
    map_waddr  = ei;
    map_wdata  = '0;
    if (state == ST_EXEC) begin
      case (req.kind)
        KIND_ASSIGN: begin
          if (a_ok && e_ok) begin
            slot_we    = where_hit;
            slot_waddr = mp.slot;
            map_we     = 1'b1;
            map_wdata  = '{placed: 1'b1, slot: pa};
          end
        end
        KIND_CLEAR: begin
          if (a_ok) begin
            slot_we   = 1'b1;
            map_we    = sa.used;
            map_waddr = sa.effect[EW-1:0];
          end
        end
        KIND_SWAP: begin
          if (a_ok && b_ok) begin
            slot_we    = 1'b1;
            slot_wdata = sb;
            map_we     = sb.used;
            map_waddr  = sb.effect[EW-1:0];
            map_wdata  = '{placed: 1'b1, slot: pa};
          end
        end
        default: begin
        end
      endcase
    end else if (state == ST_EXEC2) begin
      if (req.kind == KIND_ASSIGN) begin
        slot_we    = 1'b1;
        slot_wdata = '{used: 1'b1, effect: req.effect};
        map_we     = sa.used && (sa.effect != req.effect);
        map_waddr  = sa.effect[EW-1:0];
      end else begin
        slot_we    = 1'b1;
        slot_waddr = pb;
        slot_wdata = sa;
        map_we     = sa.used;
        map_waddr  = sa.effect[EW-1:0];
        map_wdata  = '{placed: 1'b1, slot: pb};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      res_valid <= 1'b0;
      cur_slot  <= '0;
      slot_on   <= ON_RESET;
      slot_vld  <= '0;
      map_vld   <= '0;
    end else begin
      if (res_valid && !res_stall && (state != ST_DONE)) begin
        res_valid <= 1'b0;
      end
      if (slot_we) begin
        slot_vld[slot_waddr] <= 1'b1;
      end
      if (map_we) begin
        map_vld[map_waddr] <= 1'b1;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            req   <= cmd;
            state <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          res_q <= res_next;
          state <= two_step ? ST_EXEC2 : ST_DONE;
          case (req.kind)
            KIND_ASSIGN: begin
              if (a_ok && e_ok && where_hit) begin
                slot_on[mp.slot] <= 1'b0;
              end
            end
            KIND_CLEAR: begin
              if (a_ok) begin
                slot_on[pa] <= 1'b0;
              end
            end
            KIND_SWAP: begin
              if (a_ok && b_ok && (pa != pb)) begin
                slot_on[pa] <= slot_on[pb];
                slot_on[pb] <= slot_on[pa];
              end
            end
            KIND_ENABLE: begin
              if (a_ok) begin
                slot_on[pa] <= req.enable;
              end
            end
            KIND_ACTIVE: begin
              if (a_ok) begin
                cur_slot <= pa;
              end
            end
            KIND_SWITCHES: slot_on[2:0] <= req.switches;
            KIND_DEFAULTS: begin
              slot_vld <= '0;
              map_vld  <= '0;
              slot_on  <= ON_RESET;
              cur_slot <= '0;
            end
            default: begin
            end
          endcase
        end
        ST_EXEC2: state <= ST_DONE;
        ST_DONE: begin
          if (!res_valid || !res_stall) begin
            res       <= res_q;
            res_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
      endcase
    end
  end

  `UEST_ASSERT_NEXT(a_accept_exec, cmd_valid && !cmd_stall, state == ST_EXEC)
  `UEST_ASSERT_IMP(a_exec2_kind, state == ST_EXEC2, req.kind == KIND_ASSIGN || req.kind == KIND_SWAP)
  `UEST_ASSERT_NEXT(a_done_push, state == ST_DONE && !res_valid, res_valid && state == ST_IDLE)
  `UEST_ASSERT_IMP(a_active_range, state != ST_EXEC, 32'(cur_slot) < SLOTS)

endmodule

>>> dv/effect_slot_table_checker.sv
// ---------------------------------------------------------------------------
// Effect slot table checker
// Watches the request and result channels, keeps its own copy of the slot
// table, predicts one result per accepted request and compares each
// accepted result with the oldest prediction, field by field.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module effect_slot_table_checker
  import uest_pkg::*;
#(
  parameter int SLOTS   = 8,
  parameter int EFFECTS = 3
) (
  input  logic clk,
  input  logic rst,
  input  logic cmd_valid,
  input  logic cmd_stall,
  input  cmd_t cmd,
  input  logic res_valid,
  input  logic res_stall,
  input  res_t res,
  output int   mismatches,
  output int   pending
);

  logic [EFFECT_W-1:0] slot_id     [SLOTS];
  logic                slot_full   [SLOTS];
  logic                slot_on     [SLOTS];
  logic [POS_W-1:0]    active_pos;

  res_t predicted_q [$];
  res_t want;
  int   err_total;

  function automatic void load_defaults();
    for (int i = 0; i < SLOTS; i++) begin
      slot_id[i]   = '0;
      slot_full[i] = 1'b0;
      slot_on[i]   = 1'b0;
    end
    for (int i = 0; i < 3; i++) begin
      if (i < EFFECTS) begin
        slot_id[i]   = EFFECT_W'(i);
        slot_full[i] = 1'b1;
      end
    end
    slot_on[0] = (EFFECTS > 0);
    active_pos = '0;
  endfunction

  function automatic int find_effect(logic [EFFECT_W-1:0] id);
    for (int i = 0; i < SLOTS; i++) begin
      if (slot_full[i] && slot_id[i] == id) return i;
    end
    return SLOTS;
  endfunction

  function automatic res_t apply_cmd(cmd_t c);
    res_t                r;
    int                  where;
    logic                a_in;
    logic                b_in;
    logic                e_in;
    logic [EFFECT_W-1:0] t_id;
    logic                t_full;
    logic                t_on;
    r    = '0;
    a_in = (c.pos_a < SLOTS);
    b_in = (c.pos_b < SLOTS);
    e_in = (c.effect < EFFECTS);
    case (c.kind)
      KIND_ASSIGN: begin
        if (a_in && e_in) begin
          where = find_effect(c.effect);
          if (where < SLOTS && where != c.pos_a) begin
            slot_id[where]   = '0;
            slot_full[where] = 1'b0;
            slot_on[where]   = 1'b0;
          end
          slot_id[c.pos_a]   = c.effect;
          slot_full[c.pos_a] = 1'b1;
          r.ok = 1'b1;
        end
      end
      KIND_CLEAR: begin
        if (a_in) begin
          slot_id[c.pos_a]   = '0;
          slot_full[c.pos_a] = 1'b0;
          slot_on[c.pos_a]   = 1'b0;
          r.ok = 1'b1;
        end
      end
      KIND_SWAP: begin
        if (a_in && b_in) begin
          t_id   = slot_id[c.pos_a];
          t_full = slot_full[c.pos_a];
          t_on   = slot_on[c.pos_a];
          slot_id[c.pos_a]   = slot_id[c.pos_b];
          slot_full[c.pos_a] = slot_full[c.pos_b];
          slot_on[c.pos_a]   = slot_on[c.pos_b];
          slot_id[c.pos_b]   = t_id;
          slot_full[c.pos_b] = t_full;
          slot_on[c.pos_b]   = t_on;
          r.ok = 1'b1;
        end
      end
      KIND_ENABLE: begin
        if (a_in) begin
          slot_on[c.pos_a] = c.enable;
          r.ok = 1'b1;
        end
      end
      KIND_ACTIVE: begin
        if (a_in) begin
          active_pos = c.pos_a;
          r.ok = 1'b1;
        end
      end
      KIND_SWITCHES: begin
        slot_on[0] = c.switches[0];
        slot_on[1] = c.switches[1];
        slot_on[2] = c.switches[2];
        r.ok = 1'b1;
      end
      KIND_QENABLED: begin
        if (e_in) begin
          where = find_effect(c.effect);
          if (where < SLOTS) r.is_enabled = slot_on[where];
          r.ok = 1'b1;
        end
      end
      KIND_QACTIVE: begin
        if (active_pos < SLOTS && slot_full[active_pos]) begin
          r.cur_effect = slot_id[active_pos];
          r.ok = 1'b1;
        end
      end
      KIND_DEFAULTS: begin
        load_defaults();
        r.ok = 1'b1;
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      load_defaults();
      predicted_q.delete();
      err_total = 0;
    end else begin
      if (res_valid && !res_stall) begin
        if (predicted_q.size() == 0) begin
          $error("result with no request waiting: ok=%0d is_enabled=%0d cur_effect=%0d",
                 res.ok, res.is_enabled, res.cur_effect);
          err_total++;
        end else begin
          want = predicted_q.pop_front();
          if (res.ok !== want.ok) begin
            $error("ok: expected %0d, actual %0d", want.ok, res.ok);
            err_total++;
          end
          if (res.is_enabled !== want.is_enabled) begin
            $error("is_enabled: expected %0d, actual %0d", want.is_enabled, res.is_enabled);
            err_total++;
          end
          if (res.cur_effect !== want.cur_effect) begin
            $error("cur_effect: expected %0d, actual %0d",
                   want.cur_effect, res.cur_effect);
            err_total++;
          end
        end
      end
      if (cmd_valid && !cmd_stall) predicted_q.push_back(apply_cmd(cmd));
    end
    mismatches <= err_total;
    pending    <= predicted_q.size();
  end

endmodule

>>> dv/tb_unique_effect_slot_table_top.sv
// ---------------------------------------------------------------------------
// Effect slot table testbench
// Drives directed table operations and then random request bursts with
// random gaps against random result stalls, including a long result hold
// and a full drain, and reports the checker's verdict.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_unique_effect_slot_table_top;
  import uest_pkg::*;

  localparam int SLOTS       = 8;
  localparam int EFFECTS     = 3;
  localparam int N_RANDOM    = 550;
  localparam int LONG_HOLD   = 80;
  localparam int QUIET_LIMIT = 2000;

  logic clk = 1'b0;
  logic rst;
  logic cmd_valid;
  logic cmd_stall;
  cmd_t cmd;
  logic res_valid;
  logic res_stall;
  res_t res;
  int   mismatches;
  int   pending;
  int   quiet_cycles;
  int   hold_reqs = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  unique_effect_slot_table_top #(
    .SLOTS   (SLOTS),
    .EFFECTS (EFFECTS)
  ) u_top (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

  effect_slot_table_checker #(
    .SLOTS   (SLOTS),
    .EFFECTS (EFFECTS)
  ) u_checker (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (cmd_valid),
    .cmd_stall  (cmd_stall),
    .cmd        (cmd),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .res        (res),
    .mismatches (mismatches),
    .pending    (pending)
  );

  always @(posedge clk) begin
    if (rst || (cmd_valid && !cmd_stall) || (res_valid && !res_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic [KIND_W-1:0] KW_UNKNOWN(int code);
    return KIND_W'(code);
  endfunction

  function automatic cmd_t make_cmd(logic [KIND_W-1:0] kind, logic [POS_W-1:0] pa,
                                    logic [POS_W-1:0] pb, logic [EFFECT_W-1:0] eff,
                                    logic en, logic [SW_W-1:0] sw);
    cmd_t c;
    c.kind     = kind;
    c.pos_a    = pa;
    c.pos_b    = pb;
    c.effect   = eff;
    c.enable   = en;
    c.switches = sw;
    return c;
  endfunction

  function automatic cmd_t random_cmd();
    cmd_t c;
    int   pick;
    c    = cmd_t'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 4) c.kind = KIND_DEFAULTS;
    else if (pick < 9) c.kind = KIND_W'($urandom_range(9, 15));
    else c.kind = KIND_W'($urandom_range(0, 7));
    c.pos_a  = ($urandom_range(0, 9) == 0) ? POS_W'($urandom_range(0, 15))
                                           : POS_W'($urandom_range(0, SLOTS - 1));
    c.pos_b  = ($urandom_range(0, 9) == 0) ? POS_W'($urandom_range(0, 15))
                                           : POS_W'($urandom_range(0, SLOTS - 1));
    c.effect = ($urandom_range(0, 4) == 0) ? EFFECT_W'($urandom_range(0, 15))
                                           : EFFECT_W'($urandom_range(0, EFFECTS - 1));
    return c;
  endfunction

  task automatic send_cmd(input cmd_t c);
    cmd_valid <= 1'b1;
    cmd       <= c;
    @(posedge clk);
    while (cmd_stall) @(posedge clk);
  endtask

  task automatic pause_cmds(input int n);
    cmd_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic drain_results();
    cmd_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    int seen;
    int seg_len;
    int mode;
    seen = 0;
    res_stall <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_reqs != seen) begin
        seen = hold_reqs;
        res_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        mode    = $urandom_range(0, 3);
        seg_len = $urandom_range(4, 40);
        repeat (seg_len) begin
          case (mode)
            0: res_stall <= 1'b0;
            1: res_stall <= ($urandom_range(0, 3) == 0);
            2: res_stall <= ($urandom_range(0, 1) == 0);
            default: res_stall <= ($urandom_range(0, 3) != 0);
          endcase
          @(posedge clk);
        end
      end
    end
  end

  initial begin
    int burst_left;
    int gapless;
    rst       <= 1'b1;
    cmd_valid <= 1'b0;
    cmd       <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_cmd(make_cmd(KIND_QENABLED, 0, 0, 0, 0, 0));
    send_cmd(make_cmd(KIND_QENABLED, 0, 0, 1, 0, 0));
    send_cmd(make_cmd(KIND_QENABLED, 15, 15, 15, 1, 7));
    send_cmd(make_cmd(KIND_QACTIVE, 0, 0, 0, 0, 0));
    send_cmd(make_cmd(KIND_ASSIGN, 7, 0, 2, 0, 0));
    send_cmd(make_cmd(KIND_ASSIGN, 7, 0, 2, 1, 0));
    send_cmd(make_cmd(KIND_ASSIGN, 15, 0, 0, 0, 0));
    send_cmd(make_cmd(KIND_ASSIGN, 3, 0, 3, 0, 0));
    send_cmd(make_cmd(KIND_CLEAR, 0, 0, 0, 0, 0));
    send_cmd(make_cmd(KIND_QACTIVE, 0, 0, 0, 0, 0));
    send_cmd(make_cmd(KIND_CLEAR, 8, 0, 0, 0, 0));
    send_cmd(make_cmd(KIND_SWAP, 1, 7, 0, 0, 0));
    send_cmd(make_cmd(KIND_SWAP, 4, 4, 0, 0, 0));
    send_cmd(make_cmd(KIND_SWAP, 3, 15, 0, 0, 0));
    send_cmd(make_cmd(KIND_ENABLE, 5, 0, 0, 1, 0));
    send_cmd(make_cmd(KIND_ENABLE, 9, 0, 0, 1, 0));
    send_cmd(make_cmd(KIND_ACTIVE, 1, 0, 0, 0, 0));
    send_cmd(make_cmd(KIND_QACTIVE, 0, 0, 0, 0, 0));
    send_cmd(make_cmd(KIND_ACTIVE, 10, 0, 0, 0, 0));
    send_cmd(make_cmd(KIND_SWITCHES, 0, 0, 0, 0, 7));
    send_cmd(make_cmd(KIND_QENABLED, 0, 0, 2, 0, 0));
    send_cmd(make_cmd(KIND_SWITCHES, 0, 0, 0, 0, 0));
    send_cmd(make_cmd(KW_UNKNOWN(9), 0, 0, 0, 0, 0));
    send_cmd(make_cmd(KW_UNKNOWN(15), 0, 0, 0, 0, 0));
    send_cmd(make_cmd(KIND_DEFAULTS, 0, 0, 0, 0, 0));
    send_cmd(make_cmd(KIND_QACTIVE, 0, 0, 0, 0, 0));
    drain_results();

    burst_left = $urandom_range(1, 24);
    gapless    = 0;
    for (int n = 0; n < N_RANDOM; n++) begin
      if (n == 150 || n == 420) begin
        hold_reqs++;
        gapless = 40;
      end
      if (n == 300) drain_results();
      send_cmd(random_cmd());
      if (gapless > 0) begin
        gapless--;
      end else begin
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 24);
          if ($urandom_range(0, 3) != 0) pause_cmds($urandom_range(1, 8));
        end
      end
    end

    drain_results();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
